// ----- rtl/core/txcon_pkg.sv -----
// Shared types and constants for the text console writer.
// Holds field widths, character codes, op codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package txcon_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [CHAR_W-1:0] CH_LINE_FEED  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CARRIAGE   = 8'h0d;
  localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MOVE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic capture;
    logic put_cell;
    logic adv_col;
    logic new_line;
    logic set_cursor;
    logic read_cell;
    logic clear_all;
    logic walk_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic newline_char;
    logic at_last_col;
    logic at_last_row;
    logic walk_last;
  } status_t;

endpackage

// ----- rtl/core/txcon_ctrl.sv -----
// Controller state machine for the text console writer.
// Depends on txcon_pkg; drives cmd_t to txcon_dp and reads its status_t.
module txcon_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  txcon_pkg::status_t status,
  output txcon_pkg::cmd_t    cmd,
  output logic               busy
);
  import txcon_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_INIT: begin
        // power-up wipe of the screen store, no result
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (status.op)
          OP_PUT: begin
            if (status.newline_char) begin
              cmd.new_line = 1'b1;
            end else begin
              cmd.put_cell = 1'b1;
              cmd.adv_col  = 1'b1;
              cmd.new_line = status.at_last_col;
            end
            // a new line off the bottom row scrolls: wipe the recycled row
            if (cmd.new_line && status.at_last_row) begin
              state_next = ST_WALK;
            end else begin
              cmd.finish = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = ST_WALK;
          end
          OP_MOVE: begin
            cmd.set_cursor = 1'b1;
            cmd.finish     = 1'b1;
          end
          OP_READ: begin
            cmd.read_cell = 1'b1;
            cmd.finish    = 1'b1;
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ----- rtl/core/txcon_dp.sv -----
// Datapath of the text console writer: cursor, scroll base, attribute
// register, screen store and result registers. Depends on txcon_pkg.
module txcon_dp #(
  parameter int SCREEN_COLS = txcon_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = txcon_pkg::SCREEN_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  txcon_pkg::cmd_t                 cmd,
  output txcon_pkg::status_t              status,
  input  logic [txcon_pkg::OP_W-1:0]      op,
  input  logic [txcon_pkg::CHAR_W-1:0]    char_code,
  input  logic [txcon_pkg::COL_W-1:0]     col,
  input  logic [txcon_pkg::ROW_W-1:0]     row,
  input  logic                            cfg_write,
  input  logic [txcon_pkg::ATTR_W-1:0]    cfg_data,
  output logic                            done,
  output logic [txcon_pkg::COL_W-1:0]     cursor_col,
  output logic [txcon_pkg::ROW_W-1:0]     cursor_row,
  output logic [txcon_pkg::CHAR_W-1:0]    read_char,
  output logic [txcon_pkg::ATTR_W-1:0]    read_attr
);
  import txcon_pkg::*;

  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CMW   = (CW > COL_W) ? CW : COL_W;
  localparam int RMW   = (RW > ROW_W) ? RW : ROW_W;
  localparam int DW    = CHAR_W + ATTR_W;

  // item registers
  op_t               it_op;
  logic [CHAR_W-1:0] it_char;
  logic [COL_W-1:0]  it_col;
  logic [ROW_W-1:0]  it_row;

  logic [ATTR_W-1:0] attr;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [RW-1:0]     base;      // physical row shown as logical row 0
  logic [AW-1:0]     walk_addr;
  logic [AW-1:0]     walk_end;
  logic              resp_read;
  logic [DW-1:0]     rd_data;
  logic [DW-1:0]     mem [CELLS];

  logic [CMW-1:0] col_ext;
  logic [RMW-1:0] row_ext;
  logic [CW-1:0]  sat_col;
  logic [RW-1:0]  sat_row;
  logic [CW-1:0]  sel_col;
  logic [RW-1:0]  sel_row;
  logic [RW:0]    row_sum;
  logic [RW-1:0]  phys_row;
  logic [AW-1:0]  cell_addr;
  logic [AW-1:0]  base_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;

  assign col_ext = CMW'(it_col);
  assign row_ext = RMW'(it_row);
  assign sat_col = (col_ext > CMW'(SCREEN_COLS - 1)) ? CW'(SCREEN_COLS - 1) : CW'(col_ext);
  assign sat_row = (row_ext > RMW'(SCREEN_ROWS - 1)) ? RW'(SCREEN_ROWS - 1) : RW'(row_ext);

  // reads address the target cell, puts the cursor cell
  assign sel_col = (it_op == OP_READ) ? sat_col : cur_col;
  assign sel_row = (it_op == OP_READ) ? sat_row : cur_row;

  // logical to physical row through the circular scroll base
  assign row_sum  = {1'b0, sel_row} + {1'b0, base};
  assign phys_row = (row_sum >= (RW+1)'(SCREEN_ROWS)) ?
                    RW'(row_sum - (RW+1)'(SCREEN_ROWS)) : row_sum[RW-1:0];
  assign cell_addr = AW'(phys_row) * AW'(SCREEN_COLS) + AW'(sel_col);
  assign base_addr = AW'(base) * AW'(SCREEN_COLS);

  assign status.op           = it_op;
  assign status.newline_char = (it_char == CH_LINE_FEED) || (it_char == CH_CARRIAGE);
  assign status.at_last_col  = (cur_col == CW'(SCREEN_COLS - 1));
  assign status.at_last_row  = (cur_row == RW'(SCREEN_ROWS - 1));
  assign status.walk_last    = (walk_addr == walk_end);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op   <= op_t'(op);
      it_char <= char_code;
      it_col  <= col;
      it_row  <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_write) begin
      attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      base      <= '0;
      walk_addr <= '0;
      walk_end  <= AW'(CELLS - 1);
    end else begin
      if (cmd.adv_col) begin
        cur_col <= cur_col + CW'(1);
      end
      if (cmd.new_line) begin
        cur_col <= '0;
        if (status.at_last_row) begin
          // scroll: old top row becomes the new bottom row
          base      <= (base == RW'(SCREEN_ROWS - 1)) ? '0 : base + RW'(1);
          walk_addr <= base_addr;
          walk_end  <= base_addr + AW'(SCREEN_COLS - 1);
        end else begin
          cur_row <= cur_row + RW'(1);
        end
      end
      if (cmd.set_cursor) begin
        cur_col <= sat_col;
        cur_row <= sat_row;
      end
      if (cmd.clear_all) begin
        cur_col   <= '0;
        cur_row   <= '0;
        base      <= '0;
        walk_addr <= '0;
        walk_end  <= AW'(CELLS - 1);
      end
      if (cmd.walk_step) begin
        walk_addr <= walk_addr + AW'(1);
      end
    end
  end

  assign mem_we    = cmd.put_cell | cmd.walk_step;
  assign mem_waddr = cmd.walk_step ? walk_addr : cell_addr;
  assign mem_wdata = cmd.walk_step ? '0 : {it_char, attr};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read_cell) begin
      rd_data <= mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      resp_read <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        resp_read <= cmd.read_cell;
      end
    end
  end

  assign cursor_col = COL_W'(cur_col);
  assign cursor_row = ROW_W'(cur_row);
  assign read_char  = resp_read ? rd_data[DW-1:ATTR_W] : '0;
  assign read_attr  = resp_read ? rd_data[ATTR_W-1:0] : '0;

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Top level of the text console writer: controller plus datapath.
// Depends on txcon_pkg, txcon_ctrl and txcon_dp.
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+-------------------------------------
//  item in  | start && !busy       | op, char_code, col, row
//  result   | done (one cycle)     | cursor_col, cursor_row, read_char,
//           |                      | read_attr
//  config   | cfg_write            | cfg_data (text attribute)
//
// Put, move and read are accepted, then handled in the execute state, which
// writes the cell, moves the cursor or reads the store; done is registered
// and shows in the cycle after. A put that scrolls then wipes the recycled
// row; clear wipes the whole store, one cell per cycle. After reset, busy
// stays high while the store is wiped; config writes are taken throughout.
// The receiver cannot stall: each result is valid for its single done cycle.
module text_console_writer_top #(
  parameter int SCREEN_COLS = txcon_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = txcon_pkg::SCREEN_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [txcon_pkg::OP_W-1:0]   op,
  input  logic [txcon_pkg::CHAR_W-1:0] char_code,
  input  logic [txcon_pkg::COL_W-1:0]  col,
  input  logic [txcon_pkg::ROW_W-1:0]  row,
  input  logic                         cfg_write,
  input  logic [txcon_pkg::ATTR_W-1:0] cfg_data,
  output logic                         done,
  output logic [txcon_pkg::COL_W-1:0]  cursor_col,
  output logic [txcon_pkg::ROW_W-1:0]  cursor_row,
  output logic [txcon_pkg::CHAR_W-1:0] read_char,
  output logic [txcon_pkg::ATTR_W-1:0] read_attr
);
  import txcon_pkg::*;

  cmd_t    cmd;
  status_t status;

  txcon_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  txcon_dp #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .op         (op),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .done       (done),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .read_char  (read_char),
    .read_attr  (read_attr)
  );

endmodule

// ----- rtl/core/text_console_writer_chk.sv -----
// Port-level checker for text_console_writer_top, bound to the top level.
// Depends on txcon_pkg for the op codes.
module text_console_writer_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [txcon_pkg::OP_W-1:0]   op,
  input logic                         done
);
  import txcon_pkg::*;

  // an accepted beat occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block idle right after accepting an item");

  // a move or read raises the registered done straight from its execute state, with no walk
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((op == OP_MOVE) || (op == OP_READ))) |-> ##2 done)
    else $error("move/read result missing");

  // a result appears only while the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // one result per item: strobes never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

endmodule

bind text_console_writer_top text_console_writer_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .op    (op),
  .done  (done)
);
